### sv/slcs_pkg.sv
// shared types and constants for the sampled call latency monitor
// no dependencies; imported by slcs_mod_unit and sampled_call_latency_stats
package slcs_pkg;

   localparam int THREAD_SLOTS_DEFAULT = 1024;
   localparam int CALL_IDS_DEFAULT     = 512;
   localparam logic [31:0] RATE_AT_RESET = 32'd10;

   typedef enum logic [1:0] {
      REQ_ENTER = 2'd0,
      REQ_EXIT  = 2'd1,
      REQ_READ  = 2'd2,
      REQ_SPARE = 2'd3
   } req_code_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_LOOKUP,
      ST_DIVIDE,
      ST_UPDATE
   } state_type;

   typedef struct packed {
      logic [1:0]  req_type;
      logic [9:0]  thread_slot;
      logic [63:0] timestamp;
      logic [8:0]  call_id;
      logic        returned_error;
   } req_data_type;

   typedef struct packed {
      logic        event_taken;
      logic [63:0] calls_done;
      logic [63:0] total_time;
      logic [63:0] max_time;
      logic [63:0] error_count;
      logic [63:0] sampled_total;
   } rsp_data_type;

   typedef struct packed {
      logic [63:0] calls;
      logic [63:0] time_sum;
      logic [63:0] time_max;
      logic [63:0] errors;
   } stat_entry_type;

   // divider handshake with the control sequencer
   typedef struct packed {
      logic done;
   } div_ctrl_type;

endpackage

### sv/slcs_mod_unit.sv
// iterative 64 by 32 bit remainder, one quotient bit per cycle
// depends on slcs_pkg
module slcs_mod_unit
   import slcs_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   input  logic [63:0]  dividend,
   input  logic [31:0]  divisor,
   output div_ctrl_type ctrl,
   output logic         rem_zero
);

   logic [63:0] num_ff, num_in;
   logic [32:0] rem_ff, rem_in;
   logic [31:0] div_ff, div_in;
   logic [6:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [32:0] shifted;

   // one restoring step per cycle
   always_comb begin
      num_in  = num_ff;
      rem_in  = rem_ff;
      div_in  = div_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      shifted = {rem_ff[31:0], num_ff[63]};
      if (start) begin
         num_in  = dividend;
         rem_in  = '0;
         div_in  = divisor;
         cnt_in  = 7'd64;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         num_in = {num_ff[62:0], 1'b0};
         if (shifted >= {1'b0, div_ff}) begin
            rem_in = shifted - {1'b0, div_ff};
         end else begin
            rem_in = shifted;
         end
         cnt_in = cnt_ff - 7'd1;
         if (cnt_ff == 7'd1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      num_ff <= num_in;
      rem_ff <= rem_in;
      div_ff <= div_in;
      if (reset) begin
         cnt_ff  <= '0;
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign ctrl.done  = done_ff;
   assign rem_zero   = (rem_ff == '0);

endmodule

### sv/sampled_call_latency_stats.sv
// sampled call latency monitor: one request at a time, answered after the lookup and update
// states, with the divide state between them for an enter while the rate register exceeds 1
// (64-step remainder unit). a new request is taken only after the last one leaves its update
// step; a waiting response holds the following request in its update step. after reset a
// clearing pass over max(THREAD_SLOTS, CALL_IDS) entries (1024 by default) wipes the slot and
// statistics memories while requests stall; csr writes are taken at any time.
module sampled_call_latency_stats
   import slcs_pkg::*;
#(
   parameter int THREAD_SLOTS = THREAD_SLOTS_DEFAULT,
   parameter int CALL_IDS     = CALL_IDS_DEFAULT
)
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  req_data_type req_data,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output rsp_data_type rsp_data,
   input  logic         csr_write_enable,
   input  logic [31:0]  csr_write_data
);

   localparam int SlotW    = $clog2(THREAD_SLOTS);
   localparam int CidW     = $clog2(CALL_IDS);
   localparam int ClrDepth = (THREAD_SLOTS > CALL_IDS) ? THREAD_SLOTS : CALL_IDS;
   localparam int ClrW     = $clog2(ClrDepth);

   // memories
   logic           valid_mem [THREAD_SLOTS];
   logic [63:0]    start_mem [THREAD_SLOTS];
   stat_entry_type stat_mem  [CALL_IDS];

   state_type      state_ff, state_in;
   logic [ClrW-1:0] clr_ff, clr_in;
   logic [31:0]    rate_ff;
   logic [63:0]    count_ff, count_in;
   logic [63:0]    sampled_ff, sampled_in;
   req_data_type   req_ff;
   logic [SlotW-1:0] slot_ff;
   logic [CidW-1:0]  cid_ff;
   logic           valid_rd_ff;
   logic [63:0]    start_rd_ff;
   stat_entry_type stat_rd_ff;
   logic           take_ff, take_in;
   logic           rsp_valid_ff, rsp_valid_in;
   rsp_data_type   rsp_ff, rsp_in;

   logic           accept;
   logic           div_start;
   div_ctrl_type   div_ctrl;
   logic           rem_zero;
   logic           vm_we, vm_wd, sm_we, st_we;
   logic [SlotW-1:0] vm_addr;
   logic [CidW-1:0]  st_addr;
   stat_entry_type st_wd;
   stat_entry_type st_new;
   logic [63:0]    dur;
   logic           clr_slot_ok, clr_cid_ok;

   slcs_mod_unit u_mod (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (count_ff),
      .divisor  (rate_ff),
      .ctrl     (div_ctrl),
      .rem_zero (rem_zero)
   );

   assign accept      = (state_ff == ST_IDLE) && req_valid;
   assign req_stall   = (state_ff != ST_IDLE);
   assign clr_slot_ok = (32'(clr_ff) < THREAD_SLOTS);
   assign clr_cid_ok  = (32'(clr_ff) < CALL_IDS);

   // exit update of the looked-up statistics
   always_comb begin
      dur    = req_ff.timestamp - start_rd_ff;
      st_new = stat_rd_ff;
      st_new.calls    = stat_rd_ff.calls + 64'd1;
      st_new.time_sum = stat_rd_ff.time_sum + dur;
      if (dur > stat_rd_ff.time_max) begin
         st_new.time_max = dur;
      end
      if (req_ff.returned_error) begin
         st_new.errors = stat_rd_ff.errors + 64'd1;
      end
   end

   // sequencer: next state, write ports and response
   always_comb begin
      state_in     = state_ff;
      clr_in       = clr_ff;
      count_in     = count_ff;
      sampled_in   = sampled_ff;
      take_in      = take_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_in       = rsp_ff;
      div_start    = 1'b0;
      vm_we        = 1'b0;
      vm_wd        = 1'b0;
      vm_addr      = slot_ff;
      sm_we        = 1'b0;
      st_we        = 1'b0;
      st_addr      = cid_ff;
      st_wd        = st_new;
      case (state_ff)
         ST_CLEAR: begin
            vm_we   = clr_slot_ok;
            vm_addr = clr_ff[SlotW-1:0];
            st_we   = clr_cid_ok;
            st_addr = clr_ff[CidW-1:0];
            st_wd   = '0;
            clr_in  = clr_ff + ClrW'(1);
            if (32'(clr_ff) == ClrDepth - 1) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_LOOKUP;
            end
         end
         ST_LOOKUP: begin
            if (req_ff.req_type == REQ_ENTER) begin
               if (rate_ff > 32'd1) begin
                  div_start = 1'b1;
                  state_in  = ST_DIVIDE;
               end else begin
                  take_in  = 1'b1;
                  state_in = ST_UPDATE;
               end
            end else begin
               take_in  = (req_ff.req_type == REQ_EXIT) && valid_rd_ff;
               state_in = ST_UPDATE;
            end
         end
         ST_DIVIDE: begin
            if (div_ctrl.done) begin
               take_in  = rem_zero;
               state_in = ST_UPDATE;
            end
         end
         ST_UPDATE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               state_in     = ST_IDLE;
               rsp_valid_in = 1'b1;
               rsp_in.event_taken = take_ff;
               rsp_in.calls_done  = stat_rd_ff.calls;
               rsp_in.total_time  = stat_rd_ff.time_sum;
               rsp_in.max_time    = stat_rd_ff.time_max;
               rsp_in.error_count = stat_rd_ff.errors;
               rsp_in.sampled_total = sampled_ff;
               if (req_ff.req_type == REQ_ENTER) begin
                  count_in = count_ff + 64'd1;
                  if (take_ff) begin
                     vm_we      = 1'b1;
                     vm_wd      = 1'b1;
                     sm_we      = 1'b1;
                     sampled_in = sampled_ff + 64'd1;
                     rsp_in.sampled_total = sampled_ff + 64'd1;
                  end
               end else if (take_ff) begin
                  vm_we = 1'b1;
                  st_we = 1'b1;
                  rsp_in.calls_done  = st_new.calls;
                  rsp_in.total_time  = st_new.time_sum;
                  rsp_in.max_time    = st_new.time_max;
                  rsp_in.error_count = st_new.errors;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // memory ports: registered reads at accept, one write each
   always_ff @(posedge clock) begin
      if (accept) begin
         valid_rd_ff <= valid_mem[SlotW'(32'(req_data.thread_slot) % THREAD_SLOTS)];
         start_rd_ff <= start_mem[SlotW'(32'(req_data.thread_slot) % THREAD_SLOTS)];
         stat_rd_ff  <= stat_mem[CidW'(32'(req_data.call_id) % CALL_IDS)];
      end
      if (vm_we) begin
         valid_mem[vm_addr] <= vm_wd;
      end
      if (sm_we) begin
         start_mem[slot_ff] <= req_ff.timestamp;
      end
      if (st_we) begin
         stat_mem[st_addr] <= st_wd;
      end
   end

   // request capture and response register payload
   always_ff @(posedge clock) begin
      if (accept) begin
         req_ff  <= req_data;
         slot_ff <= SlotW'(32'(req_data.thread_slot) % THREAD_SLOTS);
         cid_ff  <= CidW'(32'(req_data.call_id) % CALL_IDS);
      end
      rsp_ff  <= rsp_in;
      take_ff <= take_in;
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         count_ff     <= '0;
         sampled_ff   <= '0;
         rsp_valid_ff <= 1'b0;
         rate_ff      <= RATE_AT_RESET;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         count_ff     <= count_in;
         sampled_ff   <= sampled_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_write_enable) begin
            rate_ff <= csr_write_data;
         end
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule
